>>> src/i2c_master_register_access_macros.svh
// Assertion macros for the I2C register access master.
// Used by the RTL files that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef I2C_MASTER_REGISTER_ACCESS_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_MACROS_SVH
`ifndef SYNTHESIS
`define I2CM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("i2cm: implication check failed");
`define I2CM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("i2cm: next-cycle check failed");
`else
`define I2CM_ASSERT_IMP(label, ante, cons)
`define I2CM_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> src/i2cm_pkg.sv
// Shared types and constants for the I2C register access master.
// No dependencies; used by the engine and the top level.
package i2cm_pkg;

    localparam int MAX_BYTES_DEF = 16;

    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_LOAD  = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [4:0] byte_count;
        logic [7:0] data_byte;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       read_last;
        logic       done_res;
        logic       ack_error;
    } t_result;

endpackage

>>> src/i2cm_wbuf.sv
// Write data buffer of the I2C register access master: one write port, one
// registered read port. Depends on nothing but its parameter.
module i2cm_wbuf #(
    parameter int MAX_BYTES = 16,
    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [MAX_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Addresses past the depth only occur when the data is not used.
    always_ff @(posedge i_clk) begin
        if (32'(i_rd_addr) < MAX_BYTES) begin
            r_rd_data <= r_mem[i_rd_addr];
        end else begin
            r_rd_data <= 8'h00;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/i2cm_engine.sv
// Bus sequencer of the I2C register access master: phase machine, pin levels,
// config register. Depends on i2cm_pkg and the assertion macro header.
`include "i2c_master_register_access_macros.svh"

module i2cm_engine #(
    parameter int MAX_BYTES = i2cm_pkg::MAX_BYTES_DEF,
    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  i2cm_pkg::t_item   i_item,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [7:0]        o_wr_data,
    output logic [AW-1:0]     o_rd_addr,
    input  logic [7:0]        i_rd_data,
    output i2cm_pkg::t_result o_res
);

    localparam int CW = $clog2(MAX_BYTES + 1);
    localparam int IW = $clog2(MAX_BYTES + 2);

    typedef enum logic [4:0] {
        PH_IDLE, PH_START_SDA, PH_START_SCL, PH_TX_LOW, PH_TX_HIGH,
        PH_ACK_LOW, PH_ACK_HIGH, PH_ACK_POLL, PH_RS_LOW, PH_RS_HIGH,
        PH_RD_LOW, PH_RD_HIGH, PH_RD_SAMPLE, PH_MA_LOW, PH_MA_HIGH,
        PH_STOP_A, PH_STOP_B, PH_STOP_C
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [3:0]    r_bit_index, n_bit_index;
    logic [7:0]    r_shift, n_shift;
    logic [IW-1:0] r_byte_index, n_byte_index;
    logic [CW-1:0] r_fill, n_fill;
    logic [7:0]    r_poll, n_poll;
    logic [6:0]    r_device, n_device;
    logic [7:0]    r_register, n_register;
    logic [CW-1:0] r_count, n_count;
    logic          r_read_mode, n_read_mode;
    logic          r_aborted, n_aborted;
    logic          r_scl, n_scl;
    logic          r_sda, n_sda;
    logic          r_drv, n_drv;
    logic [7:0]    r_ack_timeout;

    logic [IW-1:0] w_next_data;
    logic          w_last;
    logic          w_valid;
    logic          w_out_last;
    logic          w_done;
    logic          w_err;
    logic [7:0]    w_rbyte;

    // The buffer entry for the next data byte is fetched every cycle; the index
    // is stable for many items before it is needed.
    assign w_next_data = r_byte_index - IW'(1);
    assign o_rd_addr   = w_next_data[AW-1:0];
    assign w_last      = (r_byte_index + IW'(1)) >= IW'(r_count);

    assign o_wr_en   = i_accept && (r_phase == PH_IDLE) && (i_item.opcode == i2cm_pkg::OP_LOAD)
                       && (32'(r_fill) < MAX_BYTES);
    assign o_wr_addr = r_fill[AW-1:0];
    assign o_wr_data = i_item.data_byte;

    always_comb begin
        n_phase      = r_phase;
        n_bit_index  = r_bit_index;
        n_shift      = r_shift;
        n_byte_index = r_byte_index;
        n_fill       = r_fill;
        n_poll       = r_poll;
        n_device     = r_device;
        n_register   = r_register;
        n_count      = r_count;
        n_read_mode  = r_read_mode;
        n_aborted    = r_aborted;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_drv        = r_drv;
        w_valid      = 1'b0;
        w_out_last   = 1'b0;
        w_done       = 1'b0;
        w_err        = 1'b0;
        w_rbyte      = 8'h00;

        if (r_phase == PH_IDLE) begin
            case (i_item.opcode)
                i2cm_pkg::OP_LOAD: begin
                    if (32'(r_fill) < MAX_BYTES) begin
                        n_fill = r_fill + CW'(1);
                    end
                end
                i2cm_pkg::OP_WRITE, i2cm_pkg::OP_READ: begin
                    n_device    = i_item.device_address;
                    n_register  = i_item.register_address;
                    if (32'(i_item.byte_count) > MAX_BYTES) begin
                        n_count = CW'(MAX_BYTES);
                    end else begin
                        n_count = CW'(i_item.byte_count);
                    end
                    n_read_mode  = (i_item.opcode == i2cm_pkg::OP_READ);
                    n_aborted    = 1'b0;
                    n_byte_index = '0;
                    n_bit_index  = '0;
                    n_poll       = '0;
                    n_shift      = {i_item.device_address, 1'b0};
                    n_scl        = 1'b1;
                    n_sda        = 1'b1;
                    n_drv        = 1'b1;
                    n_phase      = PH_START_SDA;
                end
                default: begin
                end
            endcase
        end else if (i_item.opcode == i2cm_pkg::OP_TICK) begin
            unique case (r_phase)
                PH_START_SDA: begin
                    {n_scl, n_sda, n_drv} = 3'b101;
                    n_phase = PH_START_SCL;
                end
                PH_START_SCL: begin
                    {n_scl, n_sda, n_drv} = 3'b001;
                    n_bit_index = '0;
                    n_phase = PH_TX_LOW;
                end
                PH_TX_LOW: begin
                    {n_scl, n_sda, n_drv} = {1'b0, r_shift[7], 1'b1};
                    n_phase = PH_TX_HIGH;
                end
                PH_TX_HIGH: begin
                    {n_scl, n_sda, n_drv} = {1'b1, r_shift[7], 1'b1};
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bit_index = r_bit_index + 4'd1;
                    n_phase = (n_bit_index >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
                end
                PH_ACK_LOW: begin
                    {n_scl, n_sda, n_drv} = 3'b010;
                    n_poll = '0;
                    n_phase = PH_ACK_HIGH;
                end
                PH_ACK_HIGH: begin
                    {n_scl, n_sda, n_drv} = 3'b110;
                    n_phase = PH_ACK_POLL;
                end
                PH_ACK_POLL: begin
                    {n_scl, n_sda, n_drv} = 3'b110;
                    if (i_item.sda_in) begin
                        if (r_poll == r_ack_timeout) begin
                            n_aborted = 1'b1;
                            n_phase = PH_STOP_A;
                        end else begin
                            n_poll = r_poll + 8'd1;
                        end
                    end else if (r_byte_index == '0) begin
                        // Device address acknowledged: the register address follows.
                        n_byte_index = IW'(1);
                        n_shift = r_register;
                        n_bit_index = '0;
                        n_phase = PH_TX_LOW;
                    end else if (!r_read_mode) begin
                        if (w_next_data < IW'(r_count)) begin
                            n_byte_index = r_byte_index + IW'(1);
                            n_shift = i_rd_data;
                            n_bit_index = '0;
                            n_phase = PH_TX_LOW;
                        end else begin
                            n_phase = PH_STOP_A;
                        end
                    end else if (r_byte_index == IW'(1)) begin
                        n_shift = {r_device, 1'b1};
                        n_byte_index = IW'(2);
                        n_phase = PH_RS_LOW;
                    end else if (r_count == '0) begin
                        n_phase = PH_STOP_A;
                    end else begin
                        n_byte_index = '0;
                        n_bit_index = '0;
                        n_shift = 8'h00;
                        n_phase = PH_RD_LOW;
                    end
                end
                PH_RS_LOW: begin
                    {n_scl, n_sda, n_drv} = 3'b011;
                    n_phase = PH_RS_HIGH;
                end
                PH_RS_HIGH: begin
                    {n_scl, n_sda, n_drv} = 3'b111;
                    n_phase = PH_START_SDA;
                end
                PH_RD_LOW: begin
                    {n_scl, n_sda, n_drv} = 3'b010;
                    n_phase = PH_RD_HIGH;
                end
                PH_RD_HIGH: begin
                    {n_scl, n_sda, n_drv} = 3'b110;
                    n_phase = PH_RD_SAMPLE;
                end
                PH_RD_SAMPLE: begin
                    {n_scl, n_sda, n_drv} = 3'b110;
                    n_shift = {r_shift[6:0], i_item.sda_in};
                    n_bit_index = r_bit_index + 4'd1;
                    n_phase = (n_bit_index >= 4'd8) ? PH_MA_LOW : PH_RD_LOW;
                end
                PH_MA_LOW: begin
                    {n_scl, n_sda, n_drv} = {1'b0, w_last, 1'b1};
                    n_phase = PH_MA_HIGH;
                end
                PH_MA_HIGH: begin
                    {n_scl, n_sda, n_drv} = {1'b1, w_last, 1'b1};
                    w_valid = 1'b1;
                    w_rbyte = r_shift;
                    w_out_last = w_last;
                    n_byte_index = r_byte_index + IW'(1);
                    n_bit_index = '0;
                    n_phase = w_last ? PH_STOP_A : PH_RD_LOW;
                end
                PH_STOP_A: begin
                    {n_scl, n_sda, n_drv} = 3'b001;
                    n_phase = PH_STOP_B;
                end
                PH_STOP_B: begin
                    {n_scl, n_sda, n_drv} = 3'b101;
                    n_phase = PH_STOP_C;
                end
                PH_STOP_C: begin
                    {n_scl, n_sda, n_drv} = 3'b111;
                    w_done = 1'b1;
                    w_err = r_aborted;
                    n_aborted = 1'b0;
                    if (!r_read_mode) begin
                        n_fill = '0;
                    end
                    n_phase = PH_IDLE;
                end
                default: begin
                    {n_scl, n_sda, n_drv} = 3'b111;
                    n_phase = PH_IDLE;
                end
            endcase
        end

        o_res.scl_level  = n_scl;
        o_res.sda_level  = n_sda;
        o_res.sda_drive  = n_drv;
        o_res.busy_res   = (n_phase != PH_IDLE);
        o_res.read_valid = w_valid;
        o_res.read_byte  = w_rbyte;
        o_res.read_last  = w_out_last;
        o_res.done_res   = w_done;
        o_res.ack_error  = w_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_index  <= '0;
            r_shift      <= '0;
            r_byte_index <= '0;
            r_fill       <= '0;
            r_poll       <= '0;
            r_device     <= '0;
            r_register   <= '0;
            r_count      <= '0;
            r_read_mode  <= 1'b0;
            r_aborted    <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_drv        <= 1'b1;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_bit_index  <= n_bit_index;
            r_shift      <= n_shift;
            r_byte_index <= n_byte_index;
            r_fill       <= n_fill;
            r_poll       <= n_poll;
            r_device     <= n_device;
            r_register   <= n_register;
            r_count      <= n_count;
            r_read_mode  <= n_read_mode;
            r_aborted    <= n_aborted;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_drv        <= n_drv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_ack_timeout <= i_cfg_data;
        end
    end

    `I2CM_ASSERT_IMP(a_load_only_idle, o_wr_en, r_phase == PH_IDLE)
    `I2CM_ASSERT_NXT(a_begin_starts, i_accept && (r_phase == PH_IDLE) && ((i_item.opcode == i2cm_pkg::OP_WRITE) || (i_item.opcode == i2cm_pkg::OP_READ)), r_phase == PH_START_SDA)
    `I2CM_ASSERT_NXT(a_busy_cmd_holds, i_accept && (r_phase != PH_IDLE) && (i_item.opcode != i2cm_pkg::OP_TICK), $stable(r_phase) && $stable(r_shift))
    `I2CM_ASSERT_IMP(a_abort_in_stop, r_aborted, (r_phase == PH_STOP_A) || (r_phase == PH_STOP_B) || (r_phase == PH_STOP_C))
    `I2CM_ASSERT_IMP(a_read_only_in_read, i_accept && o_res.read_valid, r_read_mode)

endmodule

>>> src/i2c_master_register_access.sv
// Top level of the I2C register access master: stream ports, output register.
// Depends on i2cm_pkg, i2cm_wbuf and i2cm_engine.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser opcode, tdata command fields
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata pins and status, tuser, tlast
//  cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_data ack timeout polls
//
// One item is taken per clock while the input is not stalled; the phase registers
// advance once per item, and the write buffer read is fetched ahead, so the rate
// is one item per cycle. Each result is registered in the output register.
// Input stalls only while that register is full and not being taken.
// Reset is synchronous; the write buffer is not cleared.
module i2c_master_register_access #(
    parameter int MAX_BYTES = i2cm_pkg::MAX_BYTES_DEF,
    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // device_address[6:0], register_address[14:7], byte_count[19:15],
    // data_byte[27:20], sda_in[28], zero fill [31:29]
    input  logic [31:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scl_level[0], sda_level[1], sda_drive[2], busy_res[3], read_byte[11:4],
    // done_res[12], ack_error[13], zero fill [15:14]
    output logic [15:0] m_axis_tdata,
    // read_valid[0]
    output logic        m_axis_tuser,
    // read_last
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    i2cm_pkg::t_item   w_item;
    i2cm_pkg::t_result w_res;
    i2cm_pkg::t_result r_out;
    logic              r_out_valid;
    logic              w_accept;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [7:0]        w_wr_data;
    logic [AW-1:0]     w_rd_addr;
    logic [7:0]        w_rd_data;

    assign w_item.opcode           = s_axis_tuser;
    assign w_item.device_address   = s_axis_tdata[6:0];
    assign w_item.register_address = s_axis_tdata[14:7];
    assign w_item.byte_count       = s_axis_tdata[19:15];
    assign w_item.data_byte        = s_axis_tdata[27:20];
    assign w_item.sda_in           = s_axis_tdata[28];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    i2cm_wbuf #(
        .MAX_BYTES(MAX_BYTES)
    ) u_wbuf (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    i2cm_engine #(
        .MAX_BYTES(MAX_BYTES)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_item    (w_item),
        .i_cfg_we  (i_cfg_valid && o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.ack_error, r_out.done_res, r_out.read_byte,
                            r_out.busy_res, r_out.sda_drive, r_out.sda_level, r_out.scl_level};
    assign m_axis_tuser  = r_out.read_valid;
    assign m_axis_tlast  = r_out.read_last;

endmodule
